@@ src/lgb_pkg.sv @@
// Shared types and codes for the leapfrog gravity body update unit.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package lgb_pkg;

   typedef logic [2:0] opcode_type;

   localparam opcode_type OP_ATTRACT = 3'd0;
   localparam opcode_type OP_CLEAR   = 3'd1;
   localparam opcode_type OP_KICK    = 3'd2;
   localparam opcode_type OP_DRIFT   = 3'd3;
   localparam opcode_type OP_SHIFT   = 3'd4;
   localparam opcode_type OP_PLACE   = 3'd5;

   localparam logic [63:0] SMAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN64 = 64'h8000_0000_0000_0000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_DIFF, ST_R2WAIT, ST_R2CHK, ST_SQWAIT, ST_PLACE,
      ST_DIVMU, ST_DMWAIT, ST_DIVS, ST_DSWAIT, ST_MULC, ST_MCWAIT, ST_DCWAIT,
      ST_MULV, ST_MVWAIT, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_LOAD, DP_DIFF, DP_R2ADD, DP_SQRT, DP_SETR, DP_PLACE, DP_DIVMU,
      DP_SETS, DP_DIVS, DP_SETS2, DP_MULC, DP_DIVC, DP_ADDACC, DP_MULV,
      DP_APPLYV, DP_CLEAR, DP_SHIFT, DP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic       mul_done;
      logic       ds_done;
      logic       r2_zero;
      opcode_type opcode;
   } status_type;

endpackage

@@ src/leapfrog_gravity_body_update_unit.sv @@
// Attract ends early at zero distance; a new word can be taken in the cycle after each
// result is registered. The 64-step root/divide unit (one bit a cycle) and the 64x64
// multiplier set the latency of each operation.
// A finished word waits in the output register while the next word is taken.
// Synchronous active-high reset zeroes position, velocity and acceleration.
// Depends on lgb_pkg, lgb_ctrl and lgb_datapath.
`timescale 1ns / 1ps

module leapfrog_gravity_body_update_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [63:0] req_other_pos_x,
   input  logic [63:0] req_other_pos_y,
   input  logic [63:0] req_other_pos_z,
   input  logic [62:0] req_other_mu,
   input  logic [62:0] req_step_h,
   input  logic [63:0] req_start_speed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_pos_x,
   output logic [63:0] rsp_pos_y,
   output logic [63:0] rsp_pos_z,
   output logic [63:0] rsp_vel_x,
   output logic [63:0] rsp_vel_y,
   output logic [63:0] rsp_vel_z,
   output logic [63:0] rsp_acc_x,
   output logic [63:0] rsp_acc_y,
   output logic [63:0] rsp_acc_z,
   output logic        rsp_saturated
);

   lgb_pkg::cmd_type    cmd;
   lgb_pkg::status_type status;

   lgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lgb_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_opcode      (req_opcode),
      .req_other_pos_x (req_other_pos_x),
      .req_other_pos_y (req_other_pos_y),
      .req_other_pos_z (req_other_pos_z),
      .req_other_mu    (req_other_mu),
      .req_step_h      (req_step_h),
      .req_start_speed (req_start_speed),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_vel_x       (rsp_vel_x),
      .rsp_vel_y       (rsp_vel_y),
      .rsp_vel_z       (rsp_vel_z),
      .rsp_acc_x       (rsp_acc_x),
      .rsp_acc_y       (rsp_acc_y),
      .rsp_acc_z       (rsp_acc_z),
      .rsp_saturated   (rsp_saturated)
   );

endmodule

@@ src/lgb_mul.sv @@
// Sequential 64 x 64 unsigned multiplier, one 32 x 32 partial product a cycle.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module lgb_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic [127:0] product,
   output logic         done
);

   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [63:0]  pp_ff, pp_in;
   logic [127:0] acc_ff, acc_in;
   logic [2:0]   phase_ff, phase_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [31:0]  op_a, op_b;
   logic [127:0] term;

   always_comb begin
      case (phase_ff[1:0])
         2'd0:    begin op_a = a_ff[31:0];  op_b = b_ff[31:0];  end
         2'd1:    begin op_a = a_ff[31:0];  op_b = b_ff[63:32]; end
         2'd2:    begin op_a = a_ff[63:32]; op_b = b_ff[31:0];  end
         default: begin op_a = a_ff[63:32]; op_b = b_ff[63:32]; end
      endcase
      case (phase_ff) inside
         3'd1:        term = {64'd0, pp_ff};
         3'd2, 3'd3:  term = {32'd0, pp_ff, 32'd0};
         3'd4:        term = {pp_ff, 64'd0};
         default:     term = '0;
      endcase
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      pp_in    = pp_ff;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in     = a;
         b_in     = b;
         acc_in   = '0;
         phase_in = 3'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         pp_in  = {32'd0, op_a} * {32'd0, op_b};
         acc_in = acc_ff + term;
         if (phase_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            phase_in = phase_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 3'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule

@@ src/lgb_divsqrt.sv @@
// Bit-serial unit: 128/64 saturating divide or 128-bit integer square root.
// One quotient or root bit a cycle; no package dependencies.
`timescale 1ns / 1ps

module lgb_divsqrt (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         sqrt_mode,
   input  logic [127:0] num,
   input  logic [63:0]  den,
   output logic [63:0]  result,
   output logic         sat,
   output logic         done
);

   logic [127:0] num_ff, num_in;
   logic [63:0]  den_ff, den_in, q_ff, q_in;
   logic [67:0]  rem_ff, rem_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         mode_ff, mode_in, busy_ff, busy_in, done_ff, done_in, sat_ff, sat_in;
   logic [64:0]  div_rem;
   logic         div_ge;
   logic [67:0]  sq_rem, sq_trial;
   logic         sq_ge;

   always_comb begin
      div_rem  = {rem_ff[63:0], num_ff[127]};
      div_ge   = div_rem >= {1'b0, den_ff};
      sq_rem   = {rem_ff[65:0], num_ff[127:126]};
      sq_trial = {2'b00, q_ff, 2'b01};
      sq_ge    = sq_rem >= sq_trial;
   end

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      busy_in = busy_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      if (start) begin
         mode_in = sqrt_mode;
         den_in  = den;
         q_in    = '0;
         cnt_in  = 6'd63;
         sat_in  = 1'b0;
         if (sqrt_mode) begin
            num_in  = num;
            rem_in  = '0;
            busy_in = 1'b1;
         end else if (num[127:64] >= den) begin
            q_in    = '1;
            sat_in  = 1'b1;
            done_in = 1'b1;
         end else begin
            num_in  = {num[63:0], 64'd0};
            rem_in  = {4'd0, num[127:64]};
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (mode_ff) begin
            num_in = {num_ff[125:0], 2'b00};
            rem_in = sq_ge ? sq_rem - sq_trial : sq_rem;
            q_in   = {q_ff[62:0], sq_ge};
         end else begin
            num_in = {num_ff[126:0], 1'b0};
            rem_in = {4'd0, div_ge ? div_rem[63:0] - den_ff : div_rem[63:0]};
            q_in   = {q_ff[62:0], div_ge};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      mode_ff <= mode_in;
      sat_ff  <= sat_in;
   end

   assign result = q_ff;
   assign sat    = sat_ff;
   assign done   = done_ff;

endmodule

@@ src/lgb_datapath.sv @@
// Datapath: body state, operand registers, saturating arithmetic, result words.
// Depends on lgb_pkg, lgb_mul and lgb_divsqrt.
`timescale 1ns / 1ps

module lgb_datapath (
   input  logic                clock,
   input  logic                reset,
   input  lgb_pkg::cmd_type    cmd,
   output lgb_pkg::status_type status,
   input  logic [2:0]          req_opcode,
   input  logic [63:0]         req_other_pos_x,
   input  logic [63:0]         req_other_pos_y,
   input  logic [63:0]         req_other_pos_z,
   input  logic [62:0]         req_other_mu,
   input  logic [62:0]         req_step_h,
   input  logic [63:0]         req_start_speed,
   output logic [63:0]         rsp_pos_x,
   output logic [63:0]         rsp_pos_y,
   output logic [63:0]         rsp_pos_z,
   output logic [63:0]         rsp_vel_x,
   output logic [63:0]         rsp_vel_y,
   output logic [63:0]         rsp_vel_z,
   output logic [63:0]         rsp_acc_x,
   output logic [63:0]         rsp_acc_y,
   output logic [63:0]         rsp_acc_z,
   output logic                rsp_saturated
);

   function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         return {1'b1, a[63] ? lgb_pkg::SMIN64 : lgb_pkg::SMAX64};
      return {1'b0, s};
   endfunction

   function automatic logic [64:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63])
         return {1'b1, a[63] ? lgb_pkg::SMIN64 : lgb_pkg::SMAX64};
      return {1'b0, s};
   endfunction

   function automatic logic [64:0] apply_sign(input logic [63:0] mag, input logic neg);
      if (!neg)
         return mag[63] ? {1'b1, lgb_pkg::SMAX64} : {1'b0, mag};
      if (mag > lgb_pkg::SMIN64)
         return {1'b1, lgb_pkg::SMIN64};
      return {1'b0, 64'd0 - mag};
   endfunction

   logic [63:0]         pos_ff [3], pos_in [3];
   logic [63:0]         vel_ff [3], vel_in [3];
   logic [63:0]         acc_ff [3], acc_in [3];
   logic [63:0]         other_ff [3], other_in [3];
   logic [63:0]         mag_ff [3], mag_in [3];
   logic                neg_ff [3], neg_in [3];
   logic [63:0]         out_pos_ff [3], out_pos_in [3];
   logic [63:0]         out_vel_ff [3], out_vel_in [3];
   logic [63:0]         out_acc_ff [3], out_acc_in [3];
   logic                out_sat_ff, out_sat_in;
   lgb_pkg::opcode_type opcode_ff, opcode_in;
   logic [62:0]         mu_ff, mu_in, h_ff, h_in;
   logic [63:0]         speed_ff, speed_in;
   logic [127:0]        r2_ff, r2_in;
   logic [63:0]         r_ff, r_in, s_ff, s_in, s2_ff, s2_in;
   logic                flag_ff, flag_in;

   logic [1:0]   ax;
   logic [63:0]  other_sel, pos_sel, vec_sel, vec_abs, base_sel;
   logic         neg_c;
   logic [63:0]  mag_c;
   logic         mul_start, mul_done, ds_start, ds_sqrt, ds_done, ds_sat;
   logic [63:0]  mul_a, mul_b, ds_den, ds_result;
   logic [127:0] mul_product, ds_num;
   logic [128:0] r2_sum;
   logic         v_over;
   logic [63:0]  v_mag;
   logic [64:0]  v_signed, v_sum, c_signed, c_sum, place_val;
   logic [64:0]  sub_c [3];

   always_comb begin
      ax        = cmd.axis;
      other_sel = other_ff[ax];
      pos_sel   = pos_ff[ax];
      neg_c     = $signed(other_sel) < $signed(pos_sel);
      mag_c     = neg_c ? pos_sel - other_sel : other_sel - pos_sel;
      vec_sel   = (opcode_ff == lgb_pkg::OP_KICK) ? acc_ff[ax] : vel_ff[ax];
      vec_abs   = vec_sel[63] ? 64'd0 - vec_sel : vec_sel;
      base_sel  = (opcode_ff == lgb_pkg::OP_KICK) ? vel_ff[ax] : pos_ff[ax];
      r2_sum    = {1'b0, r2_ff} + {1'b0, mul_product};
      if (opcode_ff == lgb_pkg::OP_KICK) begin
         v_over = |mul_product[127:97];
         v_mag  = v_over ? '1 : mul_product[96:33];
      end else begin
         v_over = |mul_product[127:96];
         v_mag  = v_over ? '1 : mul_product[95:32];
      end
      v_signed  = apply_sign(v_mag, vec_sel[63]);
      v_sum     = sat_add(base_sel, v_signed[63:0]);
      c_signed  = apply_sign(ds_result, neg_ff[ax]);
      c_sum     = sat_add(acc_ff[ax], c_signed[63:0]);
      place_val = apply_sign(r_ff, 1'b0);
      for (int i = 0; i < 3; i++)
         sub_c[i] = sat_sub(pos_ff[i], other_ff[i]);
   end

   always_comb begin
      mul_start = 1'b0;
      mul_a     = mag_c;
      mul_b     = mag_c;
      ds_start  = 1'b0;
      ds_sqrt   = 1'b0;
      ds_num    = r2_ff;
      ds_den    = r_ff;
      case (cmd.op)
         lgb_pkg::DP_DIFF: mul_start = 1'b1;
         lgb_pkg::DP_MULC: begin
            mul_start = 1'b1;
            mul_a     = s2_ff;
            mul_b     = mag_ff[ax];
         end
         lgb_pkg::DP_MULV: begin
            mul_start = 1'b1;
            mul_a     = vec_abs;
            mul_b     = {1'b0, h_ff};
         end
         lgb_pkg::DP_SQRT: begin
            ds_start = 1'b1;
            ds_sqrt  = 1'b1;
         end
         lgb_pkg::DP_DIVMU: begin
            ds_start = 1'b1;
            ds_num   = {33'd0, mu_ff, 32'd0};
         end
         lgb_pkg::DP_DIVS: begin
            ds_start = 1'b1;
            ds_num   = {32'd0, s_ff, 32'd0};
         end
         lgb_pkg::DP_DIVC: begin
            ds_start = 1'b1;
            ds_num   = mul_product;
         end
         default: ;
      endcase
   end

   always_comb begin
      pos_in     = pos_ff;
      vel_in     = vel_ff;
      acc_in     = acc_ff;
      other_in   = other_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      out_pos_in = out_pos_ff;
      out_vel_in = out_vel_ff;
      out_acc_in = out_acc_ff;
      out_sat_in = out_sat_ff;
      opcode_in  = opcode_ff;
      mu_in      = mu_ff;
      h_in       = h_ff;
      speed_in   = speed_ff;
      r2_in      = r2_ff;
      r_in       = r_ff;
      s_in       = s_ff;
      s2_in      = s2_ff;
      flag_in    = flag_ff;
      unique case (cmd.op)
         lgb_pkg::DP_LOAD: begin
            opcode_in   = req_opcode;
            other_in[0] = req_other_pos_x;
            other_in[1] = req_other_pos_y;
            other_in[2] = req_other_pos_z;
            mu_in       = req_other_mu;
            h_in        = req_step_h;
            speed_in    = req_start_speed;
            r2_in       = '0;
            flag_in     = 1'b0;
         end
         lgb_pkg::DP_DIFF: begin
            mag_in[ax] = mag_c;
            neg_in[ax] = neg_c;
         end
         lgb_pkg::DP_R2ADD: begin
            if (r2_sum[128]) begin
               r2_in   = '1;
               flag_in = 1'b1;
            end else begin
               r2_in = r2_sum[127:0];
            end
         end
         lgb_pkg::DP_SETR: r_in = ds_result;
         lgb_pkg::DP_PLACE: begin
            pos_in[0] = place_val[63:0];
            pos_in[1] = '0;
            pos_in[2] = '0;
            vel_in[0] = speed_ff;
            vel_in[1] = '0;
            vel_in[2] = '0;
            flag_in   = flag_ff | place_val[64];
         end
         lgb_pkg::DP_SETS: begin
            s_in    = ds_result;
            flag_in = flag_ff | ds_sat;
         end
         lgb_pkg::DP_SETS2: begin
            s2_in   = ds_result;
            flag_in = flag_ff | ds_sat;
         end
         lgb_pkg::DP_ADDACC: begin
            acc_in[ax] = c_sum[63:0];
            flag_in    = flag_ff | ds_sat | c_signed[64] | c_sum[64];
         end
         lgb_pkg::DP_APPLYV: begin
            if (opcode_ff == lgb_pkg::OP_KICK)
               vel_in[ax] = v_sum[63:0];
            else
               pos_in[ax] = v_sum[63:0];
            flag_in = flag_ff | v_over | v_signed[64] | v_sum[64];
         end
         lgb_pkg::DP_CLEAR: begin
            acc_in[0] = '0;
            acc_in[1] = '0;
            acc_in[2] = '0;
         end
         lgb_pkg::DP_SHIFT: begin
            pos_in[0] = sub_c[0][63:0];
            pos_in[1] = sub_c[1][63:0];
            pos_in[2] = sub_c[2][63:0];
            flag_in   = flag_ff | sub_c[0][64] | sub_c[1][64] | sub_c[2][64];
         end
         lgb_pkg::DP_RESULT: begin
            out_pos_in = pos_ff;
            out_vel_in = vel_ff;
            out_acc_in = acc_ff;
            out_sat_in = flag_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            acc_ff[i] <= '0;
         end
      end else begin
         pos_ff <= pos_in;
         vel_ff <= vel_in;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      other_ff   <= other_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      out_pos_ff <= out_pos_in;
      out_vel_ff <= out_vel_in;
      out_acc_ff <= out_acc_in;
      out_sat_ff <= out_sat_in;
      opcode_ff  <= opcode_in;
      mu_ff      <= mu_in;
      h_ff       <= h_in;
      speed_ff   <= speed_in;
      r2_ff      <= r2_in;
      r_ff       <= r_in;
      s_ff       <= s_in;
      s2_ff      <= s2_in;
      flag_ff    <= flag_in;
   end

   lgb_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_product),
      .done    (mul_done)
   );

   lgb_divsqrt u_divsqrt (
      .clock     (clock),
      .reset     (reset),
      .start     (ds_start),
      .sqrt_mode (ds_sqrt),
      .num       (ds_num),
      .den       (ds_den),
      .result    (ds_result),
      .sat       (ds_sat),
      .done      (ds_done)
   );

   always_comb begin
      status.mul_done = mul_done;
      status.ds_done  = ds_done;
      status.r2_zero  = (r2_ff == '0);
      status.opcode   = opcode_ff;
   end

   assign rsp_pos_x     = out_pos_ff[0];
   assign rsp_pos_y     = out_pos_ff[1];
   assign rsp_pos_z     = out_pos_ff[2];
   assign rsp_vel_x     = out_vel_ff[0];
   assign rsp_vel_y     = out_vel_ff[1];
   assign rsp_vel_z     = out_vel_ff[2];
   assign rsp_acc_x     = out_acc_ff[0];
   assign rsp_acc_y     = out_acc_ff[1];
   assign rsp_acc_z     = out_acc_ff[2];
   assign rsp_saturated = out_sat_ff;

endmodule

@@ src/lgb_ctrl.sv @@
// Controller: sequences each operation as datapath commands, owns the handshakes.
// Depends on lgb_pkg.
`timescale 1ns / 1ps

module lgb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  lgb_pkg::status_type status,
   output lgb_pkg::cmd_type    cmd
);

   lgb_pkg::state_type state_ff, state_in;
   logic [1:0]         axis_ff, axis_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         lgb_pkg::ST_IDLE: if (req_valid) state_in = lgb_pkg::ST_DISPATCH;
         lgb_pkg::ST_DISPATCH: begin
            axis_in = 2'd0;
            case (status.opcode) inside
               lgb_pkg::OP_ATTRACT, lgb_pkg::OP_PLACE: state_in = lgb_pkg::ST_DIFF;
               lgb_pkg::OP_KICK, lgb_pkg::OP_DRIFT:    state_in = lgb_pkg::ST_MULV;
               default:                                state_in = lgb_pkg::ST_DONE;
            endcase
         end
         lgb_pkg::ST_DIFF: state_in = lgb_pkg::ST_R2WAIT;
         lgb_pkg::ST_R2WAIT: if (status.mul_done) begin
            if (axis_ff == 2'd2) begin
               state_in = lgb_pkg::ST_R2CHK;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = lgb_pkg::ST_DIFF;
            end
         end
         lgb_pkg::ST_R2CHK:
            if (status.opcode == lgb_pkg::OP_ATTRACT && status.r2_zero)
               state_in = lgb_pkg::ST_DONE;
            else
               state_in = lgb_pkg::ST_SQWAIT;
         lgb_pkg::ST_SQWAIT: if (status.ds_done)
            state_in = (status.opcode == lgb_pkg::OP_PLACE) ? lgb_pkg::ST_PLACE
                                                            : lgb_pkg::ST_DIVMU;
         lgb_pkg::ST_PLACE: state_in = lgb_pkg::ST_DONE;
         lgb_pkg::ST_DIVMU: state_in = lgb_pkg::ST_DMWAIT;
         lgb_pkg::ST_DMWAIT: if (status.ds_done) state_in = lgb_pkg::ST_DIVS;
         lgb_pkg::ST_DIVS: state_in = lgb_pkg::ST_DSWAIT;
         lgb_pkg::ST_DSWAIT: if (status.ds_done) begin
            axis_in  = 2'd0;
            state_in = lgb_pkg::ST_MULC;
         end
         lgb_pkg::ST_MULC: state_in = lgb_pkg::ST_MCWAIT;
         lgb_pkg::ST_MCWAIT: if (status.mul_done) state_in = lgb_pkg::ST_DCWAIT;
         lgb_pkg::ST_DCWAIT: if (status.ds_done) begin
            if (axis_ff == 2'd2) begin
               state_in = lgb_pkg::ST_DONE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = lgb_pkg::ST_MULC;
            end
         end
         lgb_pkg::ST_MULV: state_in = lgb_pkg::ST_MVWAIT;
         lgb_pkg::ST_MVWAIT: if (status.mul_done) begin
            if (axis_ff == 2'd2) begin
               state_in = lgb_pkg::ST_DONE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = lgb_pkg::ST_MULV;
            end
         end
         lgb_pkg::ST_DONE: if (out_free) state_in = lgb_pkg::ST_IDLE;
         default: state_in = lgb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op       = lgb_pkg::DP_NOP;
      cmd.axis     = axis_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         lgb_pkg::ST_IDLE:   if (req_valid) cmd.op = lgb_pkg::DP_LOAD;
         lgb_pkg::ST_DISPATCH:
            case (status.opcode)
               lgb_pkg::OP_CLEAR: cmd.op = lgb_pkg::DP_CLEAR;
               lgb_pkg::OP_SHIFT: cmd.op = lgb_pkg::DP_SHIFT;
               default:           cmd.op = lgb_pkg::DP_NOP;
            endcase
         lgb_pkg::ST_DIFF:   cmd.op = lgb_pkg::DP_DIFF;
         lgb_pkg::ST_R2WAIT: if (status.mul_done) cmd.op = lgb_pkg::DP_R2ADD;
         lgb_pkg::ST_R2CHK:
            if (!(status.opcode == lgb_pkg::OP_ATTRACT && status.r2_zero))
               cmd.op = lgb_pkg::DP_SQRT;
         lgb_pkg::ST_SQWAIT: if (status.ds_done) cmd.op = lgb_pkg::DP_SETR;
         lgb_pkg::ST_PLACE:  cmd.op = lgb_pkg::DP_PLACE;
         lgb_pkg::ST_DIVMU:  cmd.op = lgb_pkg::DP_DIVMU;
         lgb_pkg::ST_DMWAIT: if (status.ds_done) cmd.op = lgb_pkg::DP_SETS;
         lgb_pkg::ST_DIVS:   cmd.op = lgb_pkg::DP_DIVS;
         lgb_pkg::ST_DSWAIT: if (status.ds_done) cmd.op = lgb_pkg::DP_SETS2;
         lgb_pkg::ST_MULC:   cmd.op = lgb_pkg::DP_MULC;
         lgb_pkg::ST_MCWAIT: if (status.mul_done) cmd.op = lgb_pkg::DP_DIVC;
         lgb_pkg::ST_DCWAIT: if (status.ds_done) cmd.op = lgb_pkg::DP_ADDACC;
         lgb_pkg::ST_MULV:   cmd.op = lgb_pkg::DP_MULV;
         lgb_pkg::ST_MVWAIT: if (status.mul_done) cmd.op = lgb_pkg::DP_APPLYV;
         lgb_pkg::ST_DONE: if (out_free) begin
            cmd.op       = lgb_pkg::DP_RESULT;
            rsp_valid_in = 1'b1;
         end
         default: cmd.op = lgb_pkg::DP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgb_pkg::ST_IDLE;
         axis_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != lgb_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == lgb_pkg::ST_DISPATCH))
      else $error("accepted word not dispatched");
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      axis_ff != 2'd3)
      else $error("axis counter out of range");
   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lgb_pkg::ST_IDLE) |-> (!status.mul_done && !status.ds_done))
      else $error("arithmetic unit finished while idle");
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lgb_pkg::ST_DONE && rsp_valid_ff && rsp_stall)
      |=> (state_ff == lgb_pkg::ST_DONE))
      else $error("result overwrote a stalled word");
`endif

endmodule
